// ===== rtl/lgs_pkg.sv =====
package lgs_pkg;

    // Widths of the command and result ports.
    localparam int OP_W   = 2;
    localparam int IDX_W  = 5;
    localparam int DATA_W = 64;

    // Neighbor count width (0 to 8 live neighbors).
    localparam int CNT_W = 4;

    // B3/S23 rule constants.
    localparam logic [CNT_W-1:0] BIRTH_CNT   = 4'd3;
    localparam logic [CNT_W-1:0] SURVIVE_CNT = 4'd2;

    // Command codes; the last code is taken and has no effect.
    typedef enum logic [OP_W-1:0] {
        OP_WRITE   = 2'd0,
        OP_ADVANCE = 2'd1,
        OP_READ    = 2'd2,
        OP_NOP     = 2'd3
    } op_t;

endpackage

// ===== rtl/life_grid_generation_step.sv =====
// Life grid of ROWS by COLS cells (B3/S23, cells beyond the edges are dead), held as a
// chain of row cells. A command is taken when start is high and busy is low. Write,
// advance and read each rotate the whole chain once through a single rule stage, one
// row per cycle, so busy stays high for ROWS cycles after the accepting edge and a new
// command can be taken ROWS+1 cycles after the previous one (33 at the default size).
// The rotation through the rule stage sets that figure. A read answers with done high
// for exactly one cycle, the first cycle in which busy is low again, with read_row valid
// in that cycle; the receiver cannot stall it, so it must take the transaction when done
// is high. Rows at or beyond ROWS read as zero and ignore writes; bits at or above COLS
// read as zero. Operation code 3 is accepted and does nothing. After reset all cells are
// dead.
module life_grid_generation_step #(
    parameter int ROWS = 32,
    parameter int COLS = 64
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [lgs_pkg::OP_W-1:0]    operation,
    input  logic [lgs_pkg::IDX_W-1:0]   row_index,
    input  logic [lgs_pkg::DATA_W-1:0]  loaded_row,
    output logic                        done,
    output logic [lgs_pkg::DATA_W-1:0]  read_row
);

    localparam int STEP_W = $clog2(ROWS);
    localparam int CMP_W  = (STEP_W > lgs_pkg::IDX_W) ? STEP_W : lgs_pkg::IDX_W;
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(ROWS - 1);

    typedef enum logic [1:0] {
        ST_IDLE  = 2'b01,
        ST_SWEEP = 2'b10
    } state_t;

    state_t                      state_reg, state_next;
    logic [STEP_W-1:0]           step_reg, step_next;
    lgs_pkg::op_t                op_reg, op_next;
    logic [lgs_pkg::IDX_W-1:0]   idx_reg, idx_next;
    logic [COLS-1:0]             data_reg, data_next;
    logic [COLS-1:0]             prev_reg, prev_next;
    logic [COLS-1:0]             rd_reg, rd_next;
    logic                        done_reg, done_next;

    logic                        accept;
    logic                        shift_en;
    logic                        first_step;
    logic                        last_step;
    logic                        hit;
    logic [COLS-1:0]             row_q [ROWS];
    logic [COLS-1:0]             above_row;
    logic [COLS-1:0]             below_row;
    logic [COLS-1:0]             rule_row;
    logic [COLS-1:0]             tail_row;

    assign accept     = start && (state_reg == ST_IDLE);
    assign shift_en   = (state_reg == ST_SWEEP);
    assign first_step = (step_reg == '0);
    assign last_step  = (step_reg == LAST_STEP);
    assign hit        = (CMP_W'(idx_reg) == CMP_W'(step_reg));

    // Chain of row cells; the head holds the row being processed, the tail takes
    // the processed row so that a full rotation puts every row back in place.
    for (genvar k = 0; k < ROWS; k++)
    begin : g_cell
        logic [COLS-1:0] d_in;
        if (k == ROWS - 1)
        begin : g_tail
            assign d_in = tail_row;
        end
        else
        begin : g_link
            assign d_in = row_q[k+1];
        end
        lgs_row_cell #(
            .COLS (COLS)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .shift_en (shift_en),
            .d_in     (d_in),
            .q        (row_q[k])
        );
    end

    // Three-row window: the old row above is kept in prev_reg, the row below is
    // still unprocessed in the next cell.
    assign above_row = first_step ? '0 : prev_reg;
    assign below_row = last_step  ? '0 : row_q[1];

    lgs_rule_row #(
        .COLS (COLS)
    ) u_rule (
        .above (above_row),
        .cur   (row_q[0]),
        .below (below_row),
        .nxt   (rule_row)
    );

    // Value written back at the tail, chosen by the command.
    always_comb
    begin
        unique case (op_reg)
            lgs_pkg::OP_ADVANCE: tail_row = rule_row;
            lgs_pkg::OP_WRITE:   tail_row = hit ? data_reg : row_q[0];
            default:             tail_row = row_q[0];
        endcase
    end

    // Sequencer: take a command, then sweep ROWS rows through the chain.
    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        op_next    = op_reg;
        idx_next   = idx_reg;
        data_next  = data_reg;
        prev_next  = prev_reg;
        rd_next    = rd_reg;
        done_next  = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && (operation != lgs_pkg::OP_NOP))
                begin
                    state_next = ST_SWEEP;
                    step_next  = '0;
                    op_next    = lgs_pkg::op_t'(operation);
                    idx_next   = row_index;
                    data_next  = loaded_row[COLS-1:0];
                    rd_next    = '0;
                end
            end
            ST_SWEEP:
            begin
                prev_next = row_q[0];
                if ((op_reg == lgs_pkg::OP_READ) && hit)
                begin
                    rd_next = row_q[0];
                end
                if (last_step)
                begin
                    state_next = ST_IDLE;
                    step_next  = '0;
                    done_next  = (op_reg == lgs_pkg::OP_READ);
                end
                else
                begin
                    step_next = step_reg + 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
                step_next  = '0;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
            op_reg    <= lgs_pkg::OP_WRITE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            op_reg    <= op_next;
            done_reg  <= done_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        idx_reg  <= idx_next;
        data_reg <= data_next;
        prev_reg <= prev_next;
        rd_reg   <= rd_next;
    end

    assign busy     = (state_reg == ST_SWEEP);
    assign done     = done_reg;
    assign read_row = lgs_pkg::DATA_W'(rd_reg);

    // A result transaction only follows the end of a sweep.
    a_done_after_sweep : assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(state_reg == ST_SWEEP))
        else $error("done without a preceding sweep");

    // The step counter rests at zero between commands.
    a_step_idle : assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> (step_reg == '0))
        else $error("step counter not at zero while idle");

    // An accepted read starts a sweep.
    a_read_starts : assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (operation == lgs_pkg::OP_READ)) |=> busy)
        else $error("accepted read did not start a sweep");

    // No result while the chain is still rotating.
    a_no_done_busy : assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !busy)
        else $error("done raised during a sweep");

endmodule

// ===== rtl/lgs_row_cell.sv =====
module lgs_row_cell #(
    parameter int COLS = 64
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            shift_en,
    input  logic [COLS-1:0] d_in,
    output logic [COLS-1:0] q
);

    logic [COLS-1:0] row_reg;

    // One grid row; it takes its neighbor's row whenever the chain shifts.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg <= '0;
        end
        else if (shift_en)
        begin
            row_reg <= d_in;
        end
    end

    assign q = row_reg;

endmodule

// ===== rtl/lgs_rule_row.sv =====
module lgs_rule_row #(
    parameter int COLS = 64
) (
    input  logic [COLS-1:0] above,
    input  logic [COLS-1:0] cur,
    input  logic [COLS-1:0] below,
    output logic [COLS-1:0] nxt
);

    // Pad each row with a dead cell on both sides so edge columns see dead neighbors.
    logic [COLS+1:0] above_pad;
    logic [COLS+1:0] cur_pad;
    logic [COLS+1:0] below_pad;

    assign above_pad = {1'b0, above, 1'b0};
    assign cur_pad   = {1'b0, cur, 1'b0};
    assign below_pad = {1'b0, below, 1'b0};

    // One independent lane per column: count the eight neighbors and apply B3/S23.
    always_comb
    begin
        logic [lgs_pkg::CNT_W-1:0] cnt;
        nxt = '0;
        for (int j = 0; j < COLS; j++)
        begin
            cnt = lgs_pkg::CNT_W'(above_pad[j]) + lgs_pkg::CNT_W'(above_pad[j+1])
                + lgs_pkg::CNT_W'(above_pad[j+2]) + lgs_pkg::CNT_W'(cur_pad[j])
                + lgs_pkg::CNT_W'(cur_pad[j+2]) + lgs_pkg::CNT_W'(below_pad[j])
                + lgs_pkg::CNT_W'(below_pad[j+1]) + lgs_pkg::CNT_W'(below_pad[j+2]);
            nxt[j] = (cnt == lgs_pkg::BIRTH_CNT)
                  || (cur[j] && (cnt == lgs_pkg::SURVIVE_CNT));
        end
    end

endmodule
